FILE: sv/sap_pkg.sv
// shared types and constants for the shelf atlas placer
// used by sap_csr, sap_ctrl and shelf_atlas_placer; no dependencies
package sap_pkg;

   localparam int MAX_SHELVES = 64;
   localparam int FIELD_W     = 15;
   localparam int ADDR_W      = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
   localparam int COUNT_W     = $clog2(MAX_SHELVES + 1);
   localparam int CSR_INDEX_W = 2;

   localparam logic [FIELD_W-1:0] ATLAS_WIDTH_RESET  = FIELD_W'(1024);
   localparam logic [FIELD_W-1:0] ATLAS_HEIGHT_RESET = FIELD_W'(1024);

   localparam logic [CSR_INDEX_W-1:0] CSR_ATLAS_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_ATLAS_HEIGHT = CSR_INDEX_W'(1);

   typedef struct packed {
      logic [FIELD_W-1:0] fill_x;
      logic [FIELD_W-1:0] top_y;
      logic [FIELD_W-1:0] height;
   } shelf_type;

   localparam int SHELF_W = $bits(shelf_type);

   typedef struct packed {
      logic [FIELD_W-1:0] width;
      logic [FIELD_W-1:0] height;
   } atlas_type;

endpackage

FILE: sv/sap_ram.sv
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module sap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/sap_csr.sv
// atlas size registers behind the configuration write channel
// depends on sap_pkg
module sap_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sap_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sap_pkg::FIELD_W-1:0]      csr_wdata,
   output sap_pkg::atlas_type               atlas
);
   import sap_pkg::*;

   atlas_type atlas_ff;
   atlas_type atlas_in;

   always_comb begin
      atlas_in = atlas_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ATLAS_WIDTH:  atlas_in.width  = csr_wdata;
            CSR_ATLAS_HEIGHT: atlas_in.height = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         atlas_ff.width  <= ATLAS_WIDTH_RESET;
         atlas_ff.height <= ATLAS_HEIGHT_RESET;
      end else begin
         atlas_ff <= atlas_in;
      end
   end

   assign csr_ready = 1'b1;
   assign atlas     = atlas_ff;

endmodule

FILE: sv/sap_ctrl.sv
// request sequencer: scans the shelf ram, picks the best-height shelf or opens a new one, writes back
// depends on sap_pkg; drives the ports of one sap_ram instance
module sap_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  sap_pkg::atlas_type           atlas,
   input  logic                         start,
   output logic                         busy,
   input  logic [sap_pkg::FIELD_W-1:0]  req_rect_width,
   input  logic [sap_pkg::FIELD_W-1:0]  req_rect_height,
   output logic                         rsp_strobe,
   output logic                         rsp_placed,
   output logic [sap_pkg::FIELD_W-1:0]  rsp_pos_x,
   output logic [sap_pkg::FIELD_W-1:0]  rsp_pos_y,
   output logic                         ram_wr_en,
   output logic [sap_pkg::ADDR_W-1:0]   ram_wr_addr,
   output sap_pkg::shelf_type           ram_wr_data,
   output logic [sap_pkg::ADDR_W-1:0]   ram_rd_addr,
   input  sap_pkg::shelf_type           ram_rd_data
);
   import sap_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE
   } state_type;

   state_type            state_ff, state_in;
   logic [FIELD_W-1:0]   w_ff, w_in;
   logic [FIELD_W-1:0]   h_ff, h_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]    eval_idx_ff, eval_idx_in;
   logic                 found_ff, found_in;
   logic [ADDR_W-1:0]    best_idx_ff, best_idx_in;
   shelf_type            best_ff, best_in;
   shelf_type            last_ff, last_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic                 rsp_placed_ff, rsp_placed_in;
   logic [FIELD_W-1:0]   rsp_pos_x_ff, rsp_pos_x_in;
   logic [FIELD_W-1:0]   rsp_pos_y_ff, rsp_pos_y_in;

   logic                 oversize;
   logic                 fits;
   logic [FIELD_W:0]     new_top;
   logic [FIELD_W+1:0]   new_bottom;

   assign oversize = (req_rect_width > atlas.width) || (req_rect_height > atlas.height);

   // candidate test on the shelf arriving from the ram this cycle
   assign fits = ({1'b0, ram_rd_data.fill_x} + {1'b0, w_ff} <= {1'b0, atlas.width})
              && ({1'b0, ram_rd_data.top_y} + {1'b0, h_ff} <= {1'b0, atlas.height})
              && (ram_rd_data.height >= h_ff)
              && (!found_ff || (ram_rd_data.height < best_ff.height));

   assign new_top    = {1'b0, last_ff.top_y} + {1'b0, last_ff.height};
   assign new_bottom = {1'b0, new_top} + {2'b00, h_ff};

   always_comb begin
      state_in      = state_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      count_in      = count_ff;
      eval_idx_in   = eval_idx_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_in       = best_ff;
      last_in       = last_ff;
      rsp_strobe_in = 1'b0;
      rsp_placed_in = rsp_placed_ff;
      rsp_pos_x_in  = rsp_pos_x_ff;
      rsp_pos_y_in  = rsp_pos_y_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = '0;
      ram_wr_data   = '0;
      ram_rd_addr   = eval_idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               w_in = req_rect_width;
               h_in = req_rect_height;
               priority if (oversize) begin
                  rsp_strobe_in = 1'b1;
                  rsp_placed_in = 1'b0;
                  rsp_pos_x_in  = '0;
                  rsp_pos_y_in  = '0;
               end else if (count_ff == '0) begin
                  // first shelf opens at the origin
                  ram_wr_en          = 1'b1;
                  ram_wr_addr        = '0;
                  ram_wr_data.fill_x = req_rect_width;
                  ram_wr_data.top_y  = '0;
                  ram_wr_data.height = req_rect_height;
                  count_in           = COUNT_W'(1);
                  rsp_strobe_in      = 1'b1;
                  rsp_placed_in      = 1'b1;
                  rsp_pos_x_in       = '0;
                  rsp_pos_y_in       = '0;
               end else begin
                  ram_rd_addr = '0;
                  eval_idx_in = '0;
                  found_in    = 1'b0;
                  state_in    = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (fits) begin
               found_in    = 1'b1;
               best_idx_in = eval_idx_ff;
               best_in     = ram_rd_data;
            end
            last_in = ram_rd_data;
            if (COUNT_W'(eval_idx_ff) + COUNT_W'(1) == count_ff) begin
               state_in = S_DECIDE;
            end else begin
               ram_rd_addr = eval_idx_ff + ADDR_W'(1);
               eval_idx_in = eval_idx_ff + ADDR_W'(1);
            end
         end
         S_DECIDE: begin
            rsp_strobe_in = 1'b1;
            rsp_placed_in = 1'b0;
            rsp_pos_x_in  = '0;
            rsp_pos_y_in  = '0;
            priority if (found_ff) begin
               ram_wr_en          = 1'b1;
               ram_wr_addr        = best_idx_ff;
               ram_wr_data.fill_x = best_ff.fill_x + w_ff;
               ram_wr_data.top_y  = best_ff.top_y;
               ram_wr_data.height = best_ff.height;
               rsp_placed_in      = 1'b1;
               rsp_pos_x_in       = best_ff.fill_x;
               rsp_pos_y_in       = best_ff.top_y;
            end else if (count_ff < COUNT_W'(MAX_SHELVES)) begin
               // open a new shelf right above the last one
               if (new_bottom <= {2'b00, atlas.height}) begin
                  ram_wr_en          = 1'b1;
                  ram_wr_addr        = count_ff[ADDR_W-1:0];
                  ram_wr_data.fill_x = w_ff;
                  ram_wr_data.top_y  = new_top[FIELD_W-1:0];
                  ram_wr_data.height = h_ff;
                  count_in           = count_ff + COUNT_W'(1);
                  rsp_placed_in      = 1'b1;
                  rsp_pos_y_in       = new_top[FIELD_W-1:0];
               end
            end else begin
               // table full: rejected
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      w_ff         <= w_in;
      h_ff         <= h_in;
      eval_idx_ff  <= eval_idx_in;
      found_ff     <= found_in;
      best_idx_ff  <= best_idx_in;
      best_ff      <= best_in;
      last_ff      <= last_in;
      rsp_placed_ff <= rsp_placed_in;
      rsp_pos_x_ff <= rsp_pos_x_in;
      rsp_pos_y_ff <= rsp_pos_y_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_placed = rsp_placed_ff;
   assign rsp_pos_x  = rsp_pos_x_ff;
   assign rsp_pos_y  = rsp_pos_y_ff;

endmodule

FILE: sv/shelf_atlas_placer.sv
// top level of the shelf atlas placer: csr block, sequencer and shelf ram
// depends on sap_pkg, sap_ram, sap_csr, sap_ctrl
//
// usage
//   a request beat (req_rect_width, req_rect_height) is taken on a clock edge with
//   start high and busy low. exactly one result beat follows on rsp_strobe for one
//   cycle: rsp_placed plus the top-left corner rsp_pos_x / rsp_pos_y (zero when
//   not placed). the receiver cannot stall; results must be taken as they come.
//   an oversize request, or any request while no shelf is open, gives its result
//   in the cycle after the accept. otherwise the sequencer reads every open shelf
//   from the shelf ram, one per cycle, then decides and writes back once, and the
//   result is registered in the decide step. busy drops in the result cycle, so
//   the next request can be taken then; requests are handled one at a time.
//   atlas_width (index 0) and atlas_height (index 1) are to be written on the csr
//   channel only while idle; the block itself does not enforce this. other indexes
//   are ignored. csr_ready is always high.
//   reset (synchronous) empties the shelf table and sets both sizes to 1024; the
//   ram itself is not cleared since only entries below the shelf count are read.
module shelf_atlas_placer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [sap_pkg::FIELD_W-1:0]      req_rect_width,
   input  logic [sap_pkg::FIELD_W-1:0]      req_rect_height,
   output logic                             rsp_strobe,
   output logic                             rsp_placed,
   output logic [sap_pkg::FIELD_W-1:0]      rsp_pos_x,
   output logic [sap_pkg::FIELD_W-1:0]      rsp_pos_y,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sap_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sap_pkg::FIELD_W-1:0]      csr_wdata
);
   import sap_pkg::*;

   atlas_type           atlas;
   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   shelf_type           ram_wr_data;
   logic [ADDR_W-1:0]   ram_rd_addr;
   shelf_type           ram_rd_data;
   logic [SHELF_W-1:0]  ram_rd_bits;

   sap_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .atlas     (atlas)
   );

   sap_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .atlas           (atlas),
      .start           (start),
      .busy            (busy),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .rsp_strobe      (rsp_strobe),
      .rsp_placed      (rsp_placed),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data)
   );

   sap_ram #(
      .WIDTH (SHELF_W),
      .DEPTH (MAX_SHELVES)
   ) u_shelf_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   assign ram_rd_data = shelf_type'(ram_rd_bits);

endmodule

FILE: tb/testbench.sv
// self-checking testbench for shelf_atlas_placer: request driver, result monitor,
// shelf packing predictor and register writes between phases; depends on sap_pkg
`timescale 1ns / 100ps

module testbench;

   localparam int FW         = sap_pkg::FIELD_W;
   localparam int SHELVES    = sap_pkg::MAX_SHELVES;
   localparam int FIELD_MAX  = 16384;
   localparam int FIELD_MASK = 'h7fff;

   // indexes the block has no register behind
   localparam logic [sap_pkg::CSR_INDEX_W-1:0] CSR_SPARE_A = sap_pkg::CSR_INDEX_W'(2);
   localparam logic [sap_pkg::CSR_INDEX_W-1:0] CSR_SPARE_B = sap_pkg::CSR_INDEX_W'(3);

   typedef struct packed {
      logic [FW-1:0] w;
      logic [FW-1:0] h;
   } rect_type;

   typedef struct packed {
      logic          placed;
      logic [FW-1:0] x;
      logic [FW-1:0] y;
   } spot_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic [FW-1:0]                   req_rect_width = '0;
   logic [FW-1:0]                   req_rect_height = '0;
   logic                            rsp_strobe;
   logic                            rsp_placed;
   logic [FW-1:0]                   rsp_pos_x;
   logic [FW-1:0]                   rsp_pos_y;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [sap_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [FW-1:0]                   csr_wdata = '0;

   shelf_atlas_placer u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .rsp_strobe      (rsp_strobe),
      .rsp_placed      (rsp_placed),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial forever #10 clock = ~clock;

   // predictor copy of the block's registers and shelf table
   int unsigned atlas_w_model = 1024;
   int unsigned atlas_h_model = 1024;
   int unsigned fill_x_model [SHELVES];
   int unsigned top_y_model  [SHELVES];
   int unsigned height_model [SHELVES];
   int unsigned open_shelves = 0;

   rect_type pending_rects [$];
   spot_type expected_spots [$];

   bit req_taken = 1'b0;
   int burst_left = 1;
   int gap_left = 0;
   int error_count = 0;
   int accepted_count = 0;
   int results_seen = 0;
   int placed_count = 0;
   int csr_beats = 0;

   task automatic flag_error(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   // best-height-fit placement; updates the shelf table as the block does
   function automatic spot_type place_rect(int unsigned w, int unsigned h);
      spot_type    spot;
      bit          found;
      int unsigned best, best_h, top, last;
      spot   = '0;
      found  = 1'b0;
      best   = 0;
      best_h = 0;
      if (w <= atlas_w_model && h <= atlas_h_model) begin
         if (open_shelves == 0) begin
            fill_x_model[0] = w;
            top_y_model[0]  = 0;
            height_model[0] = h;
            open_shelves    = 1;
            spot.placed     = 1'b1;
         end else begin
            for (int i = 0; i < open_shelves; i++) begin
               if (fill_x_model[i] + w <= atlas_w_model &&
                   top_y_model[i] + h <= atlas_h_model &&
                   height_model[i] >= h &&
                   (!found || height_model[i] < best_h)) begin
                  found  = 1'b1;
                  best   = i;
                  best_h = height_model[i];
               end
            end
            if (found) begin
               spot.placed        = 1'b1;
               spot.x             = FW'(fill_x_model[best]);
               spot.y             = FW'(top_y_model[best]);
               fill_x_model[best] = (fill_x_model[best] + w) & FIELD_MASK;
            end else if (open_shelves < SHELVES) begin
               last = open_shelves - 1;
               top  = top_y_model[last] + height_model[last];
               if (top + h <= atlas_h_model) begin
                  fill_x_model[open_shelves] = w;
                  top_y_model[open_shelves]  = top & FIELD_MASK;
                  height_model[open_shelves] = h;
                  open_shelves++;
                  spot.placed = 1'b1;
                  spot.y      = FW'(top);
               end
            end
         end
      end
      return spot;
   endfunction

   // monitor: check result beats, predict newly accepted requests and track register writes
   always @(posedge clock) begin
      spot_type due;
      req_taken = 1'b0;
      if (reset) begin
         atlas_w_model = 1024;
         atlas_h_model = 1024;
         open_shelves  = 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_spots.size() == 0) begin
               flag_error($sformatf("result beat with nothing pending: placed %0b x %0d y %0d",
                                    rsp_placed, rsp_pos_x, rsp_pos_y));
            end else begin
               due = expected_spots.pop_front();
               if (rsp_placed !== due.placed)
                  flag_error($sformatf("result %0d placed %0b, expected %0b",
                                       results_seen, rsp_placed, due.placed));
               if (rsp_pos_x !== due.x)
                  flag_error($sformatf("result %0d pos_x %0d, expected %0d",
                                       results_seen, rsp_pos_x, due.x));
               if (rsp_pos_y !== due.y)
                  flag_error($sformatf("result %0d pos_y %0d, expected %0d",
                                       results_seen, rsp_pos_y, due.y));
               results_seen++;
               if (due.placed) placed_count++;
            end
         end
         if (start && !busy) begin
            req_taken = 1'b1;
            expected_spots.push_back(place_rect(req_rect_width, req_rect_height));
            accepted_count++;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               sap_pkg::CSR_ATLAS_WIDTH:  atlas_w_model = csr_wdata;
               sap_pkg::CSR_ATLAS_HEIGHT: atlas_h_model = csr_wdata;
               default: ;
            endcase
            csr_beats++;
         end
      end
   end

   // driver: bursts of requests with random gaps
   always @(negedge clock) begin
      rect_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_rects.size() > 0) begin
            nxt = pending_rects.pop_front();
            req_rect_width  <= nxt.w;
            req_rect_height <= nxt.h;
            start           <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 10)
                                                      : $urandom_range(8, 1);
               // long gaps may outlast a table scan, short ones land mid-scan
               gap_left = ($urandom_range(3) == 0) ? $urandom_range(80, 20)
                                                    : $urandom_range(12, 0);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic add_rect(int unsigned w, int unsigned h);
      pending_rects.push_back('{w: FW'(w), h: FW'(h)});
   endtask

   task automatic add_random(int n);
      int unsigned aw, ah, base, w, h, pick;
      aw   = atlas_w_model;
      ah   = atlas_h_model;
      base = (ah / 40 > 0) ? ah / 40 : 1;
      repeat (n) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            w = $urandom_range((aw + 3) / 4);
            h = base * $urandom_range(4, 1);
         end else if (pick < 80) begin
            if ($urandom_range(1)) begin
               w = 0;
               h = base * $urandom_range(4, 1);
            end else begin
               w = $urandom_range(aw / 2);
               h = 0;
            end
         end else if (pick < 90) begin
            w = $urandom_range(aw);
            h = $urandom_range(ah);
            if ($urandom_range(1))
               w = (aw < FIELD_MAX) ? $urandom_range(FIELD_MAX, aw + 1) : FIELD_MAX;
            else
               h = (ah < FIELD_MAX) ? $urandom_range(FIELD_MAX, ah + 1) : FIELD_MAX;
         end else begin
            w = $urandom_range(FIELD_MAX);
            h = $urandom_range(FIELD_MAX);
         end
         if (w > FIELD_MAX) w = FIELD_MAX;
         if (h > FIELD_MAX) h = FIELD_MAX;
         add_rect(w, h);
      end
   endtask

   // check just after a falling edge, once the driver's updates have settled
   task automatic wait_idle();
      do begin
         @(negedge clock);
         #1;
      end while (pending_rects.size() != 0 || start || expected_spots.size() != 0);
   endtask

   task automatic write_csr(logic [sap_pkg::CSR_INDEX_W-1:0] idx, int unsigned val);
      int target;
      @(negedge clock);
      target = csr_beats + 1;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= FW'(val);
      while (csr_beats != target) @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_atlas(int unsigned w, int unsigned h);
      wait_idle();
      write_csr(sap_pkg::CSR_ATLAS_WIDTH, w);
      write_csr(sap_pkg::CSR_ATLAS_HEIGHT, h);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // reset sizes: oversize, empty table, zero sizes, best fit, no room above
      add_rect(1025, 10);
      add_rect(10, 1025);
      add_rect(FIELD_MAX, FIELD_MAX);
      add_rect(100, 40);
      add_rect(0, 0);
      add_rect(50, 20);
      add_rect(30, 80);
      add_rect(10, 30);
      add_rect(1000, 0);
      add_rect(10, 1000);
      add_rect(1024, 904);
      add_rect(0, 0);
      add_rect(1, 1);
      add_rect(16383, 0);
      add_rect(1024, 1);

      // shrink below the stored shelves, plus a write to an unused index
      wait_idle();
      write_csr(CSR_SPARE_A, $urandom_range(FIELD_MASK));
      set_atlas(64, 64);
      add_rect(64, 1);
      add_rect(0, 0);
      add_rect(65, 1);
      add_rect(1, 65);

      set_atlas(1024, 1024);
      add_random(240);
      set_atlas(1024, FIELD_MAX);
      add_random(170);
      set_atlas(FIELD_MAX, FIELD_MAX);
      add_random(170);

      // narrow atlas: full-width beats, each of which fits only on an empty shelf or a fresh one
      set_atlas(16, FIELD_MAX);
      repeat (130) add_rect(16, 0);

      repeat (2) begin
         wait_idle();
         write_csr(CSR_SPARE_A, $urandom_range(FIELD_MASK));
         write_csr(CSR_SPARE_B, $urandom_range(FIELD_MASK));
         set_atlas($urandom_range(FIELD_MAX, 1), $urandom_range(FIELD_MAX, 1));
         add_random(60);
      end

      set_atlas(300, 700);
      add_random(50);
      set_atlas(1, 1);
      add_random(40);
      set_atlas(FIELD_MAX, 1);
      add_random(30);

      wait_idle();
      repeat (80) @(posedge clock);
      if (expected_spots.size() != 0)
         flag_error($sformatf("%0d results never arrived", expected_spots.size()));

      $display("%0d requests over %0d register writes, %0d results (%0d placed, %0d rejected)",
               accepted_count, csr_beats, results_seen, placed_count,
               results_seen - placed_count);
      $display("%0d shelves open at the end, %0d mismatches", open_shelves, error_count);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #16_000_000;
      $display("timeout: %0d results of %0d requests", results_seen, accepted_count);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
